// File: hw/rtl/whitelist_table_fifo_evict_assert.svh
// Assertion macros used by the checker of the key table.
`ifndef WHITELIST_TABLE_FIFO_EVICT_ASSERT_SVH
`define WHITELIST_TABLE_FIFO_EVICT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WTFE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define WTFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: hw/rtl/wtfe_pkg.sv
`default_nettype none
package wtfe_pkg;

	// Width of one stored key and of each key half.
	localparam int KEY_W  = 128;
	localparam int HALF_W = 64;

	// Width of the reported slot number.
	localparam int SLOT_W = 4;

	typedef logic [KEY_W-1:0]  key_t;
	typedef logic [SLOT_W-1:0] slot_t;

	// Operation codes carried on cmd.
	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_INSERT = 1'b1;

	// Write controls for one table cell.
	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

	// Summary of a priority search over the cells.
	typedef struct packed {
		logic  any;
		slot_t slot;
	} pick_t;

endpackage
`default_nettype wire

// File: hw/rtl/wtfe_cell.sv
`default_nettype none
// One table entry: holds a key, compares it with the operation key and
// takes either that key or the word of its upper neighbor.
module wtfe_cell (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire wtfe_pkg::cell_ctl_t ctl,
	input  wire wtfe_pkg::key_t     key,
	input  wire wtfe_pkg::key_t     shift_in,
	output wtfe_pkg::key_t          entry,
	output logic                    match,
	output logic                    empty
);

	wtfe_pkg::key_t entry_q;

	// Entry storage; a direct load has priority over the shift.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctl.load) begin
			entry_q <= key;
		end else if (ctl.shift) begin
			entry_q <= shift_in;
		end
	end

	// Per-entry compare flags.
	assign entry = entry_q;
	assign match = (entry_q == key);
	assign empty = (entry_q == '0);

endmodule
`default_nettype wire

// File: hw/rtl/wtfe_pick.sv
`default_nettype none
// Priority search over the cell flags: lowest set position as a slot
// number.
module wtfe_pick #(
	parameter int N = 10
) (
	input  wire logic [N-1:0]  flags,
	output wtfe_pkg::pick_t    res
);

	// Scan from the lowest cell; the first set flag wins.
	always_comb begin
		logic seen;
		seen     = 1'b0;
		res.any  = 1'b0;
		res.slot = '0;
		for (int i = 0; i < N; i++) begin
			if (flags[i] && !seen) begin
				seen     = 1'b1;
				res.any  = 1'b1;
				res.slot = wtfe_pkg::slot_t'(i);
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/whitelist_table_fifo_evict.sv
`default_nettype none
// A result strobes on done after the word passes valid_s1 and the result register.
// Throughput: one command per cycle; busy is always low because the cell row
// compares every entry and writes the cells in the cycle after acceptance.
// Reset: arst_n clears every entry to zero (empty) and the valid and result flags at once.
// The receiver cannot stall; each result shows on done for one cycle.
module whitelist_table_fifo_evict #(
	parameter int TABLE_ENTRIES = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        cmd,
	input  wire logic [63:0] key_high,
	input  wire logic [63:0] key_low,
	output logic             done,
	output logic             found,
	output logic [3:0]       slot,
	output logic             evicted
);

	localparam int N = TABLE_ENTRIES;
	localparam wtfe_pkg::slot_t LAST_SLOT = wtfe_pkg::slot_t'(N - 1);

	logic           valid_s1;
	logic           cmd_s1;
	wtfe_pkg::key_t key_s1;

	wtfe_pkg::key_t      entries [N];
	logic [N-1:0]        match_v;
	logic [N-1:0]        empty_v;
	logic [N-1:0]        empty_first;
	wtfe_pkg::pick_t     match_res;
	wtfe_pkg::pick_t     empty_res;
	wtfe_pkg::cell_ctl_t ctl [N];

	logic is_insert;
	logic full_insert;

	logic           done_q;
	logic           found_q;
	wtfe_pkg::slot_t slot_q;
	logic           evicted_q;

	assign busy = 1'b0;

	// Capture the command word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd;
			key_s1 <= {key_high, key_low};
		end
	end

	// Row of cells; each shifts in the word of its upper neighbor, the top cell the new key.
	for (genvar i = 0; i < N; i++) begin : g_cell
		wtfe_pkg::key_t shift_src;
		if (i < N - 1) begin : g_mid
			assign shift_src = entries[i+1];
		end else begin : g_top
			assign shift_src = key_s1;
		end
		wtfe_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl[i]),
			.key      (key_s1),
			.shift_in (shift_src),
			.entry    (entries[i]),
			.match    (match_v[i]),
			.empty    (empty_v[i])
		);
	end

	// Lowest matching entry and lowest empty entry.
	wtfe_pick #(.N(N)) u_pick_match (
		.flags (match_v),
		.res   (match_res)
	);

	wtfe_pick #(.N(N)) u_pick_empty (
		.flags (empty_v),
		.res   (empty_res)
	);

	// One-hot mark of the lowest empty entry.
	assign empty_first = empty_v & ~(empty_v - N'(1));

	assign is_insert   = valid_s1 && (cmd_s1 == wtfe_pkg::CMD_INSERT);
	assign full_insert = is_insert && !empty_res.any;

	// Cell write controls: fill the lowest hole, or shift and append on top.
	always_comb begin
		for (int i = 0; i < N; i++) begin
			ctl[i].load  = is_insert && empty_first[i];
			ctl[i].shift = full_insert;
		end
		ctl[N-1].load = (is_insert && empty_first[N-1]) || full_insert;
	end

	// Result register with its strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q    <= 1'b0;
			found_q   <= 1'b0;
			evicted_q <= 1'b0;
		end else begin
			done_q    <= valid_s1;
			found_q   <= valid_s1 && (cmd_s1 == wtfe_pkg::CMD_LOOKUP) && match_res.any;
			evicted_q <= full_insert;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			unique case (cmd_s1)
				wtfe_pkg::CMD_LOOKUP: slot_q <= match_res.slot;
				wtfe_pkg::CMD_INSERT: slot_q <= empty_res.any ? empty_res.slot : LAST_SLOT;
				default:              slot_q <= '0;
			endcase
		end
	end

	assign done    = done_q;
	assign found   = found_q;
	assign slot    = slot_q;
	assign evicted = evicted_q;

endmodule
`default_nettype wire

// File: hw/rtl/wtfe_checker.sv
`default_nettype none
`include "whitelist_table_fifo_evict_assert.svh"
// Port-level checks on the key table.
module wtfe_checker #(
	parameter int TABLE_ENTRIES = 10
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       done,
	input wire logic       found,
	input wire logic [3:0] slot,
	input wire logic       evicted
);

	localparam wtfe_pkg::slot_t LAST_SLOT = wtfe_pkg::slot_t'(TABLE_ENTRIES - 1);

	// Every accepted word yields a result after it passes valid_s1 and the result register.
	`WTFE_ASSERT_NEXT(a_result_follows, clk, arst_n, start && !busy, ##1 done)
	// A result never appears without an accepted word behind it.
	`WTFE_ASSERT_SAME(a_no_spurious, clk, arst_n, done, $past(start && !busy, 2))
	// An eviction reports the last slot and no hit.
	`WTFE_ASSERT_SAME(a_evict_last, clk, arst_n, done && evicted, !found && slot == LAST_SLOT)

endmodule

bind whitelist_table_fifo_evict wtfe_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_wtfe_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.start   (start),
	.busy    (busy),
	.done    (done),
	.found   (found),
	.slot    (slot),
	.evicted (evicted)
);
`default_nettype wire

// File: tb/sv/testbench.sv
`default_nettype none
module testbench;

	localparam int TABLE_ENTRIES = 10;
	localparam int POOL_KEYS     = 16;

	// One reply word as the table reports it.
	typedef struct {
		logic            found;
		wtfe_pkg::slot_t slot;
		logic            evicted;
	} table_reply_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        start    = 1'b0;
	logic        cmd      = wtfe_pkg::CMD_LOOKUP;
	logic [63:0] key_high = '0;
	logic [63:0] key_low  = '0;
	logic        busy;
	logic        done;
	logic        found;
	logic [3:0]  slot;
	logic        evicted;

	// Shadow copy of the key table and the replies still owed by the block.
	wtfe_pkg::key_t shadow_keys [TABLE_ENTRIES];
	table_reply_t   replies_due [$];
	wtfe_pkg::key_t key_pool [POOL_KEYS];
	int             mismatches = 0;
	int             idle_pct   = 0;

	whitelist_table_fifo_evict #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.cmd     (cmd),
		.key_high(key_high),
		.key_low (key_low),
		.done    (done),
		.found   (found),
		.slot    (slot),
		.evicted (evicted)
	);

	always #1 clk = ~clk;

	// Give up if the run hangs.
	initial begin
		#200000;
		$display("end of test: mismatches");
		$finish;
	end

	// Apply one accepted word to the shadow table and work out its reply.
	task automatic table_access(input logic op, input wtfe_pkg::key_t key,
			output table_reply_t r);
		int  i;
		bit  hit;
		r.found   = 1'b0;
		r.slot    = '0;
		r.evicted = 1'b0;
		hit       = 1'b0;
		if (op == wtfe_pkg::CMD_LOOKUP) begin
			for (i = 0; i < TABLE_ENTRIES; i++) begin
				if (!hit && shadow_keys[i] == key) begin
					hit     = 1'b1;
					r.found = 1'b1;
					r.slot  = i[wtfe_pkg::SLOT_W-1:0];
				end
			end
		end else begin
			// The lowest empty slot takes the key.
			for (i = 0; i < TABLE_ENTRIES; i++) begin
				if (!hit && shadow_keys[i] == '0) begin
					hit            = 1'b1;
					shadow_keys[i] = key;
					r.slot         = i[wtfe_pkg::SLOT_W-1:0];
				end
			end
			// Full table: drop the oldest, shift down and append.
			if (!hit) begin
				for (i = 0; i < TABLE_ENTRIES - 1; i++)
					shadow_keys[i] = shadow_keys[i+1];
				shadow_keys[TABLE_ENTRIES-1] = key;
				r.slot    = wtfe_pkg::SLOT_W'(TABLE_ENTRIES - 1);
				r.evicted = 1'b1;
			end
		end
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Check each reply word against the oldest prediction, then predict
	// the word accepted at this edge. Both look at values from before the edge.
	always @(posedge clk) begin
		table_reply_t want;
		table_reply_t next_reply;
		if (arst_n) begin
			if (done) begin
				if (replies_due.size() == 0) begin
					$display("%0t: unexpected word, expected none, %s%0b %0d %0b",
						$time, "actual found/slot/evicted ", found, slot, evicted);
					mismatches++;
				end else begin
					want = replies_due.pop_front();
					check_field("found", int'(want.found), int'(found));
					check_field("slot", int'(want.slot), int'(slot));
					check_field("evicted", int'(want.evicted), int'(evicted));
				end
			end
			if (start && !busy) begin
				table_access(cmd, {key_high, key_low}, next_reply);
				replies_due.push_back(next_reply);
			end
		end
	end

	// Present one command word and hold it until the block takes it.
	task automatic send_word(input logic op, input wtfe_pkg::key_t key);
		start    <= 1'b1;
		cmd      <= op;
		key_high <= key[127:64];
		key_low  <= key[63:0];
		@(posedge clk);
		while (busy) @(posedge clk);
		// Each following cycle idles at the chosen rate.
		while ($urandom_range(99) < idle_pct) begin
			start    <= 1'b0;
			cmd      <= 1'($urandom_range(1));
			key_high <= {$urandom, $urandom};
			key_low  <= {$urandom, $urandom};
			@(posedge clk);
		end
	endtask

	// Stop sending and let every owed reply come back.
	task automatic drain_replies;
		start <= 1'b0;
		while (replies_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	function automatic wtfe_pkg::key_t random_key();
		return {$urandom, $urandom, $urandom, $urandom};
	endfunction

	// Mostly keys that were seen before, so lookups hit; some zero and fresh keys.
	function automatic wtfe_pkg::key_t pick_key();
		int             r;
		wtfe_pkg::key_t k;
		r = $urandom_range(99);
		if (r < 8)
			k = '0;
		else if (r < 14)
			k = $urandom_range(1) ? {64'd0, $urandom, $urandom} : {$urandom, $urandom, 64'd0};
		else if (r < 70)
			k = key_pool[$urandom_range(POOL_KEYS - 1)];
		else begin
			k = random_key();
			key_pool[$urandom_range(POOL_KEYS - 1)] = k;
		end
		return k;
	endfunction

	// Empty table, zero key, fill, duplicates and eviction of the oldest entry.
	task automatic test_directed;
		int i;
		send_word(wtfe_pkg::CMD_LOOKUP, '0);
		send_word(wtfe_pkg::CMD_LOOKUP, '1);
		send_word(wtfe_pkg::CMD_INSERT, '1);
		send_word(wtfe_pkg::CMD_INSERT, '0);
		send_word(wtfe_pkg::CMD_LOOKUP, '1);
		send_word(wtfe_pkg::CMD_LOOKUP, '0);
		send_word(wtfe_pkg::CMD_INSERT, {64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555});
		send_word(wtfe_pkg::CMD_INSERT, {64'h8000_0000_0000_0000, 64'd1});
		for (i = 2; i < TABLE_ENTRIES; i++)
			send_word(wtfe_pkg::CMD_INSERT, {64'(i), ~64'(i)});
		send_word(wtfe_pkg::CMD_INSERT, '1);
		send_word(wtfe_pkg::CMD_LOOKUP, '0);
		send_word(wtfe_pkg::CMD_INSERT, {64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA});
		send_word(wtfe_pkg::CMD_LOOKUP, '1);
		send_word(wtfe_pkg::CMD_INSERT, '0);
		send_word(wtfe_pkg::CMD_LOOKUP, '0);
		send_word(wtfe_pkg::CMD_INSERT, {64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210});
		send_word(wtfe_pkg::CMD_LOOKUP, {64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210});
	endtask

	task automatic test_random(input int words);
		int i;
		for (i = 0; i < words; i++)
			send_word($urandom_range(1) ? wtfe_pkg::CMD_INSERT : wtfe_pkg::CMD_LOOKUP,
				pick_key());
	endtask

	initial begin
		int i;
		for (i = 0; i < TABLE_ENTRIES; i++)
			shadow_keys[i] = '0;
		for (i = 0; i < POOL_KEYS; i++)
			key_pool[i] = random_key();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		drain_replies();

		idle_pct = 10;
		test_random(330);
		drain_replies();

		idle_pct = 84;
		test_random(330);
		drain_replies();

		idle_pct = 0;
		test_random(340);
		drain_replies();

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
`default_nettype wire
